[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the checker files.
// Each macro expects clk_i, and ASSERT_CLK also rst_ni, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, muted while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/vr2d_pkg.sv]
// ----------------------------------------------------------------------------
// vr2d_pkg
// Types, constants, saturation and sign-extension helpers for the 2-D vector reflect pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vr2d_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQRT_STAGES   = 32;

  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } clamp_t;

  // per-item context carried alongside the math
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               sat;
    logic               nx_neg;
    logic               ny_neg;
    logic [31:0]        mx;
    logic [31:0]        my;
  } carry_t;

  typedef struct packed {
    logic [63:0] x;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] r;
    logic        b;
    logic [31:0] q;
  } comp_t;

  typedef struct packed {
    logic [31:0] len;
    comp_t       cx;
    comp_t       cy;
  } div_t;

  function automatic clamp_t sat32(input logic signed [65:0] v);
    clamp_t c;
    if (v > MAX32) begin
      c.val = 32'sh7FFF_FFFF;
      c.hit = 1'b1;
    end else if (v < MIN32) begin
      c.val = 32'sh8000_0000;
      c.hit = 1'b1;
    end else begin
      c.val = v[31:0];
      c.hit = 1'b0;
    end
    return c;
  endfunction

  function automatic logic signed [65:0] sx64(input logic signed [63:0] v);
    return $signed({{2{v[63]}}, v});
  endfunction

  function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
    return $signed({{34{v[31]}}, v});
  endfunction

endpackage

`default_nettype wire

[hw/rtl/vr2d_if.sv]
// ----------------------------------------------------------------------------
// vr2d_if
// Valid/ready stream interfaces for vector pairs in and reflected vectors out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vr2d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;

  modport source (output valid, vec_x, vec_y, axis_x, axis_y, input ready);
  modport sink   (input valid, vec_x, vec_y, axis_x, axis_y, output ready);
endinterface

interface vr2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               saturated;

  modport source (output valid, out_x, out_y, saturated, input ready);
  modport sink   (input valid, out_x, out_y, saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/vr2d_front.sv]
// ----------------------------------------------------------------------------
// vr2d_front
// Six stages: v.a, n = v - (v.a)a, magnitudes and squared length of n.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vr2d_front #(
  parameter int unsigned FRAC_BITS = vr2d_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] vx_i,
  input  logic signed [31:0] vy_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  output logic               valid_o,
  output vr2d_pkg::carry_t   carry_o,
  output logic [63:0]        sq_o
);
  import vr2d_pkg::*;

  logic [5:0] v_q;

  // stage 1
  logic signed [31:0] vx1_q, vy1_q, ax1_q, ay1_q;
  logic signed [63:0] px1_q, py1_q;
  // stage 2
  logic signed [31:0] vx2_q, vy2_q, ax2_q, ay2_q, d1_q;
  logic               sat2_q;
  // stage 3
  logic signed [31:0] vx3_q, vy3_q;
  logic signed [63:0] qx3_q, qy3_q;
  logic               sat3_q;
  // stage 4
  logic signed [31:0] vx4_q, vy4_q, nx4_q, ny4_q;
  logic               sat4_q;
  // stage 5
  carry_t             c5_q;
  logic [63:0]        sqx5_q, sqy5_q;
  // stage 6
  carry_t             c6_q;
  logic [63:0]        sq6_q;

  logic signed [63:0] shx2, shy2, shx4, shy4;
  clamp_t             d1_d, tx_d, ty_d, nx_d, ny_d;
  logic [31:0]        mx_d, my_d;

  always_comb begin
    shx2 = px1_q >>> FRAC_BITS;
    shy2 = py1_q >>> FRAC_BITS;
    d1_d = sat32(sx64(shx2) + sx64(shy2));
    shx4 = qx3_q >>> FRAC_BITS;
    shy4 = qy3_q >>> FRAC_BITS;
    tx_d = sat32(sx64(shx4));
    ty_d = sat32(sx64(shy4));
    nx_d = sat32(sx32(vx3_q) - sx32(tx_d.val));
    ny_d = sat32(sx32(vy3_q) - sx32(ty_d.val));
    mx_d = nx4_q[31] ? 32'(-nx4_q) : 32'(nx4_q);
    my_d = ny4_q[31] ? 32'(-ny4_q) : 32'(ny4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx1_q  <= vx_i;
      vy1_q  <= vy_i;
      ax1_q  <= ax_i;
      ay1_q  <= ay_i;
      px1_q  <= vx_i * ax_i;
      py1_q  <= vy_i * ay_i;

      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      d1_q   <= d1_d.val;
      sat2_q <= d1_d.hit;

      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
      qx3_q  <= d1_q * ax2_q;
      qy3_q  <= d1_q * ay2_q;
      sat3_q <= sat2_q;

      vx4_q  <= vx3_q;
      vy4_q  <= vy3_q;
      nx4_q  <= nx_d.val;
      ny4_q  <= ny_d.val;
      sat4_q <= sat3_q | tx_d.hit | ty_d.hit | nx_d.hit | ny_d.hit;

      c5_q.vx     <= vx4_q;
      c5_q.vy     <= vy4_q;
      c5_q.sat    <= sat4_q;
      c5_q.nx_neg <= nx4_q[31];
      c5_q.ny_neg <= ny4_q[31];
      c5_q.mx     <= mx_d;
      c5_q.my     <= my_d;
      sqx5_q      <= mx_d * mx_d;
      sqy5_q      <= my_d * my_d;

      c6_q  <= c5_q;
      sq6_q <= sqx5_q + sqy5_q;
    end
  end

  assign valid_o = v_q[5];
  assign carry_o = c6_q;
  assign sq_o    = sq6_q;

endmodule

`default_nettype wire

[hw/rtl/vr2d_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// vr2d_sqrt_stage
// One result bit of the restoring integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vr2d_sqrt_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vr2d_pkg::sqrt_t  sqrt_i,
  input  vr2d_pkg::carry_t carry_i,
  output logic             valid_o,
  output vr2d_pkg::sqrt_t  sqrt_o,
  output vr2d_pkg::carry_t carry_o
);
  import vr2d_pkg::*;

  logic    valid_q;
  sqrt_t   sqrt_q, sqrt_d;
  carry_t  carry_q;
  logic [34:0] rem2, trial;

  always_comb begin
    rem2   = {sqrt_i.rem[32:0], sqrt_i.x[63:62]};
    trial  = {1'b0, sqrt_i.root, 2'b01};
    sqrt_d.x = {sqrt_i.x[61:0], 2'b00};
    if (rem2 >= trial) begin
      sqrt_d.rem  = rem2 - trial;
      sqrt_d.root = {sqrt_i.root[30:0], 1'b1};
    end else begin
      sqrt_d.rem  = rem2;
      sqrt_d.root = {sqrt_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqrt_q  <= sqrt_d;
      carry_q <= carry_i;
    end
  end

  assign valid_o = valid_q;
  assign sqrt_o  = sqrt_q;
  assign carry_o = carry_q;

endmodule

`default_nettype wire

[hw/rtl/vr2d_div_stage.sv]
// ----------------------------------------------------------------------------
// vr2d_div_stage
// One quotient bit of both unit-vector divisions |n| * 2^F / len.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vr2d_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vr2d_pkg::div_t   div_i,
  input  vr2d_pkg::carry_t carry_i,
  output logic             valid_o,
  output vr2d_pkg::div_t   div_o,
  output vr2d_pkg::carry_t carry_o
);
  import vr2d_pkg::*;

  logic   valid_q;
  div_t   div_q, div_d;
  carry_t carry_q;

  function automatic comp_t step(input comp_t c, input logic [31:0] len);
    comp_t       n;
    logic [32:0] t;
    logic        ge;
    t  = {c.r, c.b};
    ge = (t >= {1'b0, len});
    n.r = ge ? 32'(t - {1'b0, len}) : t[31:0];
    n.b = 1'b0;
    n.q = {c.q[30:0], ge};
    return n;
  endfunction

  always_comb begin
    div_d.len = div_i.len;
    div_d.cx  = step(div_i.cx, div_i.len);
    div_d.cy  = step(div_i.cy, div_i.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q   <= div_d;
      carry_q <= carry_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign carry_o = carry_q;

endmodule

`default_nettype wire

[hw/rtl/vr2d_back.sv]
// ----------------------------------------------------------------------------
// vr2d_back
// Four stages: v.u, s = 2(v.u), v - s*u; the last stage is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vr2d_back #(
  parameter int unsigned FRAC_BITS = vr2d_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vr2d_pkg::carry_t   carry_i,
  input  vr2d_pkg::div_t     div_i,
  output logic               valid_o,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic               sat_o
);
  import vr2d_pkg::*;

  logic [3:0] v_q;

  // stage 1
  logic signed [31:0] vx1_q, vy1_q, ux1_q, uy1_q;
  logic signed [63:0] px1_q, py1_q;
  logic               sat1_q, zero1_q;
  // stage 2
  logic signed [31:0] vx2_q, vy2_q, ux2_q, uy2_q, s2_q;
  logic               sat2_q, zero2_q;
  // stage 3
  logic signed [31:0] vx3_q, vy3_q;
  logic signed [63:0] qx3_q, qy3_q;
  logic               sat3_q, zero3_q;
  // stage 4 / output
  logic signed [31:0] rx4_q, ry4_q;
  logic               sat4_q;

  logic signed [31:0] ux_d, uy_d;
  logic signed [63:0] shx2, shy2, shx4, shy4;
  clamp_t             d2_d, s_d, pxc_d, pyc_d, rx_d, ry_d;

  always_comb begin
    ux_d = carry_i.nx_neg ? -$signed(div_i.cx.q) : $signed(div_i.cx.q);
    uy_d = carry_i.ny_neg ? -$signed(div_i.cy.q) : $signed(div_i.cy.q);
    shx2 = px1_q >>> FRAC_BITS;
    shy2 = py1_q >>> FRAC_BITS;
    d2_d = sat32(sx64(shx2) + sx64(shy2));
    s_d  = sat32($signed({{33{d2_d.val[31]}}, d2_d.val, 1'b0}));
    shx4 = qx3_q >>> FRAC_BITS;
    shy4 = qy3_q >>> FRAC_BITS;
    pxc_d = sat32(sx64(shx4));
    pyc_d = sat32(sx64(shy4));
    rx_d  = sat32(sx32(vx3_q) - sx32(pxc_d.val));
    ry_d  = sat32(sx32(vy3_q) - sx32(pyc_d.val));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx1_q   <= carry_i.vx;
      vy1_q   <= carry_i.vy;
      ux1_q   <= ux_d;
      uy1_q   <= uy_d;
      px1_q   <= carry_i.vx * ux_d;
      py1_q   <= carry_i.vy * uy_d;
      sat1_q  <= carry_i.sat;
      zero1_q <= (div_i.len == '0);

      vx2_q   <= vx1_q;
      vy2_q   <= vy1_q;
      ux2_q   <= ux1_q;
      uy2_q   <= uy1_q;
      s2_q    <= s_d.val;
      sat2_q  <= sat1_q | (!zero1_q & (d2_d.hit | s_d.hit));
      zero2_q <= zero1_q;

      vx3_q   <= vx2_q;
      vy3_q   <= vy2_q;
      qx3_q   <= s2_q * ux2_q;
      qy3_q   <= s2_q * uy2_q;
      sat3_q  <= sat2_q;
      zero3_q <= zero2_q;

      // zero-length n: reflection is skipped and v passes through
      rx4_q  <= zero3_q ? vx3_q : rx_d.val;
      ry4_q  <= zero3_q ? vy3_q : ry_d.val;
      sat4_q <= sat3_q |
                (!zero3_q & (pxc_d.hit | pyc_d.hit | rx_d.hit | ry_d.hit));
    end
  end

  assign valid_o = v_q[3];
  assign rx_o    = rx4_q;
  assign ry_o    = ry4_q;
  assign sat_o   = sat4_q;

endmodule

`default_nettype wire

[hw/rtl/vector_reflect_2d.sv]
// ----------------------------------------------------------------------------
// vector_reflect_2d
// Reflects a signed fixed-point 2-D vector about the line of an axis vector.
// ----------------------------------------------------------------------------
// One vector pair (v, a), Q16.16 by default, is taken per clock and one
// reflected vector leaves per clock once the pipe is full and while results
// are read. The pipe has 6 front stages for v.a, n and |n|^2, 32 square-root
// stages (one root bit each), FRAC_BITS + 1 divider stages (one quotient bit
// each, x and y side by side) and 4 back stages ending in the output
// register. The whole pipe shares one advance enable, taken from the output
// register: when a result sits unread, every stage holds and in_i.ready drops
// in the same cycle. saturated reports any clamp to the signed 32-bit range
// along the way; when n has zero length, back-stage clamps are ignored and
// the result is v itself.
`timescale 1ns / 1ps
`default_nettype none

module vector_reflect_2d #(
  parameter int unsigned FRAC_BITS = vr2d_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vr2d_in_if.sink     in_i,
  vr2d_out_if.source  out_o
);
  import vr2d_pkg::*;

  localparam int unsigned DivStages = FRAC_BITS + 1;

  logic en;          // global advance: output slot free or being read
  logic out_valid;

  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;

  // ---- front: dot product, n, squared length ----
  logic        f_valid;
  carry_t      f_carry;
  logic [63:0] f_sq;

  vr2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .vx_i    (in_i.vec_x),
    .vy_i    (in_i.vec_y),
    .ax_i    (in_i.axis_x),
    .ay_i    (in_i.axis_y),
    .valid_o (f_valid),
    .carry_o (f_carry),
    .sq_o    (f_sq)
  );

  // ---- square root: one bit per stage ----
  logic   sq_v [0:SQRT_STAGES];
  sqrt_t  sq_s [0:SQRT_STAGES];
  carry_t sq_c [0:SQRT_STAGES];

  assign sq_v[0]      = f_valid;
  assign sq_s[0].x    = f_sq;
  assign sq_s[0].rem  = '0;
  assign sq_s[0].root = '0;
  assign sq_c[0]      = f_carry;

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    vr2d_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .sqrt_i  (sq_s[i]),
      .carry_i (sq_c[i]),
      .valid_o (sq_v[i+1]),
      .sqrt_o  (sq_s[i+1]),
      .carry_o (sq_c[i+1])
    );
  end

  // ---- divider: |n| * 2^F / len, one quotient bit per stage ----
  // |n_x| <= len, so the quotient never exceeds 2^FRAC_BITS.
  logic   dv_v [0:DivStages];
  div_t   dv_s [0:DivStages];
  carry_t dv_c [0:DivStages];

  assign dv_v[0]      = sq_v[SQRT_STAGES];
  assign dv_s[0].len  = sq_s[SQRT_STAGES].root;
  assign dv_s[0].cx.r = {1'b0, sq_c[SQRT_STAGES].mx[31:1]};
  assign dv_s[0].cx.b = sq_c[SQRT_STAGES].mx[0];
  assign dv_s[0].cx.q = '0;
  assign dv_s[0].cy.r = {1'b0, sq_c[SQRT_STAGES].my[31:1]};
  assign dv_s[0].cy.b = sq_c[SQRT_STAGES].my[0];
  assign dv_s[0].cy.q = '0;
  assign dv_c[0]      = sq_c[SQRT_STAGES];

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    vr2d_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[j]),
      .div_i   (dv_s[j]),
      .carry_i (dv_c[j]),
      .valid_o (dv_v[j+1]),
      .div_o   (dv_s[j+1]),
      .carry_o (dv_c[j+1])
    );
  end

  // ---- back: second dot product and reflection, output register ----
  vr2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v[DivStages]),
    .carry_i (dv_c[DivStages]),
    .div_i   (dv_s[DivStages]),
    .valid_o (out_valid),
    .rx_o    (out_o.out_x),
    .ry_o    (out_o.out_y),
    .sat_o   (out_o.saturated)
  );

  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

[hw/rtl/vr2d_checker.sv]
// ----------------------------------------------------------------------------
// vr2d_checker
// Port-level checks on the output handshake and the shared pipe stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vr2d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_x_i,
  input wire logic [31:0] out_y_i,
  input wire logic        out_sat_i
);

  `ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `ASSERT_CLK(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i) && $stable(out_sat_i), "result changed while stalled")
  `ASSERT_ALWAYS(a_ready_free, !out_valid_i |-> in_ready_i, "input blocked with empty output")
  `ASSERT_CLK(a_stall_in, out_valid_i && !out_ready_i |-> !in_ready_i, "input taken during stall")

endmodule

bind vector_reflect_2d vr2d_checker u_vr2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .out_sat_i   (out_o.saturated)
);

`default_nettype wire
